>>> rtl/cef_pkg.sv
// cef_pkg: widths, constants and the queue entry type of the CUSUM event filter.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package cef_pkg;

    // Port widths fixed by the block's fields
    localparam int SPOT_W = 32;
    localparam int THR_W  = 31;
    localparam int EV_W   = 2;

    // Datapath sizing
    localparam int PRICE_W = 32;
    localparam int FRAC_BITS = 30;
    localparam int RET_W = FRAC_BITS + 2;
    localparam int SUM_W = (FRAC_BITS + 4 > THR_W + 2) ? FRAC_BITS + 4 : THR_W + 2;
    localparam int CNT_W = $clog2(FRAC_BITS);

    // Decoupling queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10737418);

    // Event codes
    localparam logic signed [EV_W-1:0] EV_NONE = 2'sb00;
    localparam logic signed [EV_W-1:0] EV_UP   = 2'sb01;
    localparam logic signed [EV_W-1:0] EV_DOWN = 2'sb11;

    // Classified item handed from front to back
    typedef struct packed {
        logic               used;     // both prices usable, return accumulates
        logic               neg;      // price fell
        logic               clipped;  // rise of at least twice the previous price
        logic               ip;       // integer part of a rise (0 or 1)
        logic [PRICE_W-1:0] num;      // dividend, below den when used and not clipped
        logic [PRICE_W-1:0] den;      // previous price
    } q_entry_t;

endpackage

>>> rtl/cef_if.sv
// cef_if: valid/ready channel interfaces for price input, results and threshold writes.
// Depends on cef_pkg.
`timescale 1ns / 1ps

interface cef_price_if;
    logic                       valid;
    logic                       ready;
    logic [cef_pkg::SPOT_W-1:0] spot_price;

    modport source (output valid, output spot_price, input ready);
    modport sink (input valid, input spot_price, output ready);
endinterface

interface cef_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [cef_pkg::EV_W-1:0] event_res;
    logic                            return_used;
    logic                            return_clipped;

    modport source (output valid, output event_res, output return_used,
                    output return_clipped, input ready);
    modport sink (input valid, input event_res, input return_used,
                  input return_clipped, output ready);
endinterface

interface cef_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [cef_pkg::THR_W-1:0] event_threshold;

    modport source (output valid, output event_threshold, input ready);
    modport sink (input valid, input event_threshold, output ready);
endinterface

>>> rtl/cusum_event_filter.sv
// cusum_event_filter: top level of the symmetric CUSUM event filter.
// Depends on cef_pkg, cef_if, cef_front, cef_queue and cef_back.
`timescale 1ns / 1ps

// Symmetric CUSUM event filter. Each price transfer on "spot" yields exactly one
// transfer on "result", in order. When a previous price exists and both it and the
// current price are nonzero, the relative return (spot - prev) / prev is formed with
// FRAC_BITS fraction bits, rounded toward zero and saturated at just under 2
// (return_clipped); it is added to an up arm floored at 0 and a down arm capped at 0.
// The up arm reaching event_threshold gives +1 and clears that arm, else the down arm
// reaching -event_threshold gives -1 and clears that arm, else 0. The front takes a
// price every cycle while its two-entry queue has room; the back drains the queue
// one item at a time. An item with a computed, unclipped return passes through the
// one-bit-per-cycle restoring divider; other items skip it. The cfg channel is
// always ready and should be written only while the block is idle.

module cusum_event_filter (
    input  logic         clk,
    input  logic         rst_n,
    cef_price_if.sink    spot,
    cef_result_if.source result,
    cef_cfg_if.sink      cfg
);

    // Threshold register, Q(FRAC_BITS) fraction of return
    logic [cef_pkg::THR_W-1:0] thr_reg;
    logic [cef_pkg::THR_W-1:0] thr_next;

    // Front-to-queue and queue-to-back hookup
    logic              q_full;
    logic              q_push;
    cef_pkg::q_entry_t q_in;
    logic              q_pop;
    logic              q_valid;
    cef_pkg::q_entry_t q_head;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        if (cfg.valid)
            thr_next = cfg.event_threshold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= cef_pkg::THR_RESET;
        else
            thr_reg <= thr_next;
    end

    // Front: previous price tracking and return classification
    cef_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .spot   (spot),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // Queue decouples input stalls from divider and output stalls
    cef_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back: divider, arms, result register
    cef_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (thr_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .result    (result)
    );

endmodule

>>> rtl/cef_front.sv
// cef_front: takes price transfers, tracks the previous price, classifies the return.
// Depends on cef_pkg and cef_if.
`timescale 1ns / 1ps

module cef_front (
    input  logic              clk,
    input  logic              rst_n,
    cef_price_if.sink         spot,
    input  logic              q_full,
    output logic              q_push,
    output cef_pkg::q_entry_t q_data
);

    logic [cef_pkg::PRICE_W-1:0] last_price_reg;
    logic [cef_pkg::PRICE_W-1:0] last_price_next;
    logic                        have_last_reg;
    logic                        have_last_next;

    logic [cef_pkg::PRICE_W-1:0] spot_val;
    logic [cef_pkg::PRICE_W-1:0] diff_up;
    logic [cef_pkg::PRICE_W-1:0] diff_dn;
    logic [cef_pkg::PRICE_W-1:0] rem_up;
    logic                        rise;
    logic                        over;
    logic                        clip;
    logic                        usable;
    logic                        accept;

    assign spot.ready = !q_full;
    assign accept     = spot.valid && spot.ready;
    assign q_push     = accept;

    always_comb
    begin
        spot_val = cef_pkg::PRICE_W'(spot.spot_price);
        diff_up  = spot_val - last_price_reg;
        diff_dn  = last_price_reg - spot_val;
        rise     = spot_val >= last_price_reg;
        // diff >= 2*prev, compared one bit wider
        clip     = {1'b0, diff_up} >= {last_price_reg, 1'b0};
        over     = diff_up >= last_price_reg;
        rem_up   = over ? (diff_up - last_price_reg) : diff_up;
        usable   = have_last_reg && (last_price_reg != '0) && (spot_val != '0);

        q_data.used    = usable;
        q_data.neg     = !rise;
        q_data.clipped = usable && rise && clip;
        q_data.ip      = rise && over;
        q_data.num     = rise ? rem_up : diff_dn;
        q_data.den     = last_price_reg;

        last_price_next = last_price_reg;
        have_last_next  = have_last_reg;
        if (accept)
        begin
            last_price_next = spot_val;
            have_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_price_reg <= '0;
            have_last_reg  <= 1'b0;
        end
        else
        begin
            last_price_reg <= last_price_next;
            have_last_reg  <= have_last_next;
        end
    end

endmodule

>>> rtl/cef_queue.sv
// cef_queue: short FIFO of classified items between front and back.
// Depends on cef_pkg.
`timescale 1ns / 1ps

module cef_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cef_pkg::q_entry_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output cef_pkg::q_entry_t head
);

    cef_pkg::q_entry_t           mem_reg [cef_pkg::QDEPTH];
    logic [cef_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [cef_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [cef_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [cef_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [cef_pkg::QCNT_W-1:0]  count_reg;
    logic [cef_pkg::QCNT_W-1:0]  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full      = count_reg == cef_pkg::QCNT_W'(cef_pkg::QDEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == cef_pkg::QPTR_W'(cef_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == cef_pkg::QPTR_W'(cef_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/cef_back.sv
// cef_back: bit-serial fraction divider, CUSUM arms and the result register.
// Depends on cef_pkg and cef_if.
`timescale 1ns / 1ps

module cef_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cef_pkg::THR_W-1:0] threshold,
    input  logic                      q_valid,
    input  cef_pkg::q_entry_t         q_head,
    output logic                      q_pop,
    cef_result_if.source              result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_ACC  = 3'b100
    } back_state_t;

    back_state_t                        state_reg, state_next;
    logic [cef_pkg::PRICE_W-1:0]        num_reg, num_next;
    logic [cef_pkg::PRICE_W-1:0]        den_reg, den_next;
    logic [cef_pkg::FRAC_BITS-1:0]      quo_reg, quo_next;
    logic [cef_pkg::CNT_W-1:0]          cnt_reg, cnt_next;
    logic                               used_reg, used_next;
    logic                               neg_reg, neg_next;
    logic                               clip_reg, clip_next;
    logic                               ip_reg, ip_next;
    logic signed [cef_pkg::SUM_W-1:0]   up_reg, up_next;
    logic signed [cef_pkg::SUM_W-1:0]   down_reg, down_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [cef_pkg::EV_W-1:0]    ev_reg, ev_next;
    logic                               out_used_reg, out_used_next;
    logic                               out_clip_reg, out_clip_next;

    logic [cef_pkg::PRICE_W:0]          rem_sh;
    logic                               ge;
    logic [cef_pkg::PRICE_W:0]          rem_sub;
    logic signed [cef_pkg::RET_W-1:0]   ret;
    logic signed [cef_pkg::RET_W-1:0]   pos_mag;
    logic signed [cef_pkg::SUM_W-1:0]   ret_ext;
    logic signed [cef_pkg::SUM_W-1:0]   up_add;
    logic signed [cef_pkg::SUM_W-1:0]   down_add;
    logic signed [cef_pkg::SUM_W-1:0]   up_clamp;
    logic signed [cef_pkg::SUM_W-1:0]   down_clamp;
    logic signed [cef_pkg::SUM_W-1:0]   thr_pos;
    logic signed [cef_pkg::SUM_W-1:0]   thr_neg;
    logic                               out_free;
    logic                               fire_up;
    logic                               fire_dn;

    assign out_free = !out_valid_reg || result.ready;

    assign result.valid          = out_valid_reg;
    assign result.event_res      = ev_reg;
    assign result.return_used    = out_used_reg;
    assign result.return_clipped = out_clip_reg;

    // One restoring-division step per cycle
    always_comb
    begin
        rem_sh  = {num_reg, 1'b0};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // Return and arm update
    always_comb
    begin
        pos_mag = {1'b0, ip_reg, quo_reg};
        if (clip_reg)
            ret = {1'b0, {(cef_pkg::RET_W - 1){1'b1}}};
        else if (neg_reg)
            ret = -pos_mag;
        else
            ret = pos_mag;
        ret_ext    = {{(cef_pkg::SUM_W - cef_pkg::RET_W){ret[cef_pkg::RET_W-1]}}, ret};
        up_add     = up_reg + ret_ext;
        down_add   = down_reg + ret_ext;
        up_clamp   = up_add[cef_pkg::SUM_W-1] ? '0 : up_add;
        down_clamp = (!down_add[cef_pkg::SUM_W-1] && down_add != '0) ? '0 : down_add;
        thr_pos    = $signed({{(cef_pkg::SUM_W - cef_pkg::THR_W){1'b0}}, threshold});
        thr_neg    = -thr_pos;
        fire_up    = up_clamp >= thr_pos;
        fire_dn    = down_clamp <= thr_neg;
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        neg_next       = neg_reg;
        clip_next      = clip_reg;
        ip_next        = ip_reg;
        up_next        = up_reg;
        down_next      = down_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ev_next        = ev_reg;
        out_used_next  = out_used_reg;
        out_clip_next  = out_clip_reg;
        q_pop          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    num_next  = q_head.num;
                    den_next  = q_head.den;
                    quo_next  = '0;
                    used_next = q_head.used;
                    neg_next  = q_head.neg;
                    clip_next = q_head.clipped;
                    ip_next   = q_head.ip;
                    cnt_next  = cef_pkg::CNT_W'(cef_pkg::FRAC_BITS - 1);
                    if (q_head.used && !q_head.clipped)
                        state_next = ST_DIV;
                    else
                        state_next = ST_ACC;
                end
            end
            ST_DIV:
            begin
                num_next = ge ? rem_sub[cef_pkg::PRICE_W-1:0] : rem_sh[cef_pkg::PRICE_W-1:0];
                quo_next = {quo_reg[cef_pkg::FRAC_BITS-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_used_next  = used_reg;
                    out_clip_next  = clip_reg;
                    ev_next        = cef_pkg::EV_NONE;
                    if (used_reg)
                    begin
                        up_next   = up_clamp;
                        down_next = down_clamp;
                        if (fire_up)
                        begin
                            up_next = '0;
                            ev_next = cef_pkg::EV_UP;
                        end
                        else if (fire_dn)
                        begin
                            down_next = '0;
                            ev_next   = cef_pkg::EV_DOWN;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        used_reg     <= used_next;
        neg_reg      <= neg_next;
        clip_reg     <= clip_next;
        ip_reg       <= ip_next;
        ev_reg       <= ev_next;
        out_used_reg <= out_used_next;
        out_clip_reg <= out_clip_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            up_reg        <= '0;
            down_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            up_reg        <= up_next;
            down_reg      <= down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Arms stay on their side of zero
    a_up_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !up_reg[cef_pkg::SUM_W-1])
        else $error("up arm went negative");

    a_down_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        down_reg[cef_pkg::SUM_W-1] || down_reg == '0)
        else $error("down arm went positive");

    // A nonzero event or a clip always comes from an accumulated return
    a_event_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (ev_reg != cef_pkg::EV_NONE || out_clip_reg) |-> out_used_reg)
        else $error("event or clip without accumulated return");

    // An up event leaves the up arm cleared
    a_up_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACC && out_free && used_reg && fire_up |=> up_reg == '0)
        else $error("up arm not cleared after up event");

    // The queue is popped only from idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE && q_valid)
        else $error("pop outside idle");

endmodule
